FILE: design/tqle_pkg.sv
// Shared types, codes and reset values of the tabular Q-learning engine.
package tqle_pkg;

	localparam int NUM_STATES_DEF = 131072;

	localparam int VAL_W   = 24;
	localparam int RATE_W  = 16;
	localparam int STEP_W  = 23;
	localparam int ROW_W   = 17;
	localparam int CFGI_W  = 3;

	// Item operation codes.
	localparam logic [1:0] OP_SELECT = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_WRITE  = 2'd2;

	// Command classes handed from the front to the back.
	localparam logic [2:0] K_NONE     = 3'd0;
	localparam logic [2:0] K_SELECT   = 3'd1;
	localparam logic [2:0] K_SEL_MISS = 3'd2;
	localparam logic [2:0] K_UPDATE   = 3'd3;
	localparam logic [2:0] K_UPD_MISS = 3'd4;
	localparam logic [2:0] K_WRITE    = 3'd5;

	// Configuration register indexes.
	localparam logic [CFGI_W-1:0] REG_ALPHA         = 3'd0;
	localparam logic [CFGI_W-1:0] REG_DISCOUNT      = 3'd1;
	localparam logic [CFGI_W-1:0] REG_EXPLORE_DECAY = 3'd2;
	localparam logic [CFGI_W-1:0] REG_EXPLORE_FLOOR = 3'd3;
	localparam logic [CFGI_W-1:0] REG_STEPS_LIMIT   = 3'd4;

	localparam logic [RATE_W-1:0] ALPHA_RST         = 16'd6554;
	localparam logic [RATE_W-1:0] DISCOUNT_RST      = 16'd58982;
	localparam logic [RATE_W-1:0] EXPLORE_DECAY_RST = 16'd65503;
	localparam logic [RATE_W-1:0] EXPLORE_FLOOR_RST = 16'd655;
	localparam logic [STEP_W-1:0] STEPS_LIMIT_RST   = 23'd5000000;
	localparam logic [RATE_W-1:0] EXPLORE_RATE_RST  = 16'hFFFF;

	typedef struct packed {
		logic [1:0]              op;
		logic [ROW_W-1:0]        state_index;
		logic [1:0]              action;
		logic [ROW_W-1:0]        next_state_index;
		logic signed [VAL_W-1:0] reward;
		logic [RATE_W-1:0]       random_draw;
		logic [1:0]              random_action;
		logic signed [VAL_W-1:0] entry_value;
	} tqle_req_t;

	typedef struct packed {
		logic [1:0]              chosen_action;
		logic                    exploring;
		logic signed [VAL_W-1:0] q_value;
		logic [RATE_W-1:0]       exploration_now;
		logic [STEP_W-1:0]       steps_done;
	} tqle_rsp_t;

	typedef struct packed {
		logic [2:0] kind;
		tqle_req_t  item;
	} tqle_cmd_t;

	typedef struct packed {
		logic [RATE_W-1:0] alpha;
		logic [RATE_W-1:0] discount;
		logic [RATE_W-1:0] explore_decay;
		logic [RATE_W-1:0] explore_floor;
		logic [STEP_W-1:0] training_steps_limit;
	} tqle_cfg_t;

endpackage

FILE: design/tqle_front.sv
// Front part: takes items off the command port and classifies them for the back part.
module tqle_front import tqle_pkg::*; #(
	parameter int NUM_STATES = NUM_STATES_DEF
) (
	input  logic      start,
	input  tqle_req_t req,
	input  logic      full,
	output logic      busy,
	output logic      push,
	output tqle_cmd_t cmd
);

	logic s_ok;
	logic ns_ok;

	assign s_ok  = 32'(req.state_index) < 32'(NUM_STATES);
	assign ns_ok = 32'(req.next_state_index) < 32'(NUM_STATES);

	assign busy = full;
	assign push = start & ~full;

	always_comb begin
		cmd.item = req;
		case (req.op)
			OP_SELECT: cmd.kind = s_ok ? K_SELECT : K_SEL_MISS;
			OP_UPDATE: cmd.kind = (s_ok && ns_ok) ? K_UPDATE : K_UPD_MISS;
			OP_WRITE:  cmd.kind = s_ok ? K_WRITE : K_NONE;
			default:   cmd.kind = K_NONE;
		endcase
	end

endmodule

FILE: design/tqle_fifo.sv
// Two-entry command queue between the front and the back part.
module tqle_fifo import tqle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tqle_cmd_t wdata,
	input  logic      pop,
	output tqle_cmd_t rdata,
	output logic      full,
	output logic      empty
);

	tqle_cmd_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: design/tqle_back.sv
// Back part: value table memory, read sequencer, update arithmetic and learning state.
module tqle_back import tqle_pkg::*; #(
	parameter int NUM_STATES = NUM_STATES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tqle_cfg_t cfg,
	input  logic      empty,
	input  tqle_cmd_t head,
	output logic      pop,
	output logic      done,
	output tqle_rsp_t rsp
);

	localparam int RW    = $clog2(NUM_STATES);
	localparam int AW    = RW + 2;
	localparam int DEPTH = NUM_STATES * 4;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_SEL  = 3'd2;
	localparam logic [2:0] ST_MULG = 3'd3;
	localparam logic [2:0] ST_TGT  = 3'd4;
	localparam logic [2:0] ST_MULA = 3'd5;
	localparam logic [2:0] ST_MULB = 3'd6;
	localparam logic [2:0] ST_WB   = 3'd7;

	logic [2:0]              state_q;
	tqle_cmd_t               cmd_q;
	logic [2:0]              rd_cnt_q;
	logic [2:0]              dcnt_q;
	logic                    rdv_q;
	logic signed [VAL_W-1:0] best_q;
	logic [1:0]              col_q;
	logic signed [VAL_W-1:0] old_q;
	logic signed [40:0]      gprod_q;
	logic [31:0]             dprod_q;
	logic signed [25:0]      tgt_q;
	logic signed [41:0]      pa_q;
	logic signed [42:0]      pb_q;
	logic [RATE_W-1:0]       rate_q;
	logic [STEP_W-1:0]       step_q;
	logic                    done_q;
	tqle_rsp_t               rsp_q;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] mem_q;
	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	logic [VAL_W-1:0] mem_wd;

	logic                    is_upd;
	logic [2:0]              n_reads;
	logic signed [43:0]      mix;
	logic signed [27:0]      mix_sh;
	logic signed [VAL_W-1:0] nv;
	logic [RATE_W-1:0]       dec_r;
	logic [RATE_W-1:0]       rate_next;
	logic                    step_go;
	logic                    emit;
	tqle_rsp_t               rsp_d;
	logic [16:0]             lr_inv;
	logic signed [VAL_W-1:0] rd_val;

	assign is_upd  = cmd_q.kind == K_UPDATE;
	assign n_reads = is_upd ? 3'd5 : 3'd4;
	assign pop     = (state_q == ST_IDLE) && !empty;
	assign rd_val  = $signed(mem_q);
	assign lr_inv  = 17'h10000 - {1'b0, cfg.alpha};

	// Blend of old value and target, floored by 16 bits and saturated.
	assign mix    = 44'(pa_q) + 44'(pb_q);
	assign mix_sh = $signed(mix[43:16]);
	always_comb begin
		if (mix_sh > 28'sd8388607) begin
			nv = 24'sh7FFFFF;
		end else if (mix_sh < -28'sd8388608) begin
			nv = -24'sd8388608;
		end else begin
			nv = mix_sh[VAL_W-1:0];
		end
	end

	assign dec_r     = dprod_q[31:16];
	assign rate_next = (dec_r < cfg.explore_floor) ? cfg.explore_floor : dec_r;
	assign step_go   = step_q < cfg.training_steps_limit;

	// Single table port: the write of a write item, the row reads and the write back.
	always_comb begin
		mem_we   = 1'b0;
		mem_wd   = nv;
		mem_addr = {RW'(cmd_q.item.state_index), cmd_q.item.action};
		case (state_q)
			ST_IDLE: begin
				mem_addr = {RW'(head.item.state_index), head.item.action};
				mem_wd   = head.item.entry_value;
				mem_we   = pop && (head.kind == K_WRITE);
			end
			ST_RD: begin
				if (rd_cnt_q[2]) begin
					mem_addr = {RW'(cmd_q.item.state_index), cmd_q.item.action};
				end else if (is_upd) begin
					mem_addr = {RW'(cmd_q.item.next_state_index), rd_cnt_q[1:0]};
				end else begin
					mem_addr = {RW'(cmd_q.item.state_index), rd_cnt_q[1:0]};
				end
			end
			ST_WB: begin
				mem_we = is_upd;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		mem_q <= mem[mem_addr];
	end

	always_comb begin
		emit                  = 1'b0;
		rsp_d.chosen_action   = cmd_q.item.action;
		rsp_d.exploring       = 1'b0;
		rsp_d.q_value         = '0;
		rsp_d.exploration_now = rate_q;
		rsp_d.steps_done      = step_q;
		case (state_q)
			ST_IDLE: begin
				rsp_d.chosen_action = head.item.action;
				if (!empty) begin
					case (head.kind)
						K_SEL_MISS: begin
							emit                = 1'b1;
							rsp_d.chosen_action = head.item.random_action;
							rsp_d.exploring     = 1'b1;
						end
						K_WRITE: begin
							emit          = 1'b1;
							rsp_d.q_value = head.item.entry_value;
						end
						K_NONE: begin
							emit = 1'b1;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			ST_SEL: begin
				emit          = 1'b1;
				rsp_d.q_value = best_q;
				if (cmd_q.item.random_draw < rate_q) begin
					rsp_d.chosen_action = cmd_q.item.random_action;
					rsp_d.exploring     = 1'b1;
				end else begin
					rsp_d.chosen_action = col_q;
				end
			end
			ST_WB: begin
				emit          = 1'b1;
				rsp_d.q_value = is_upd ? nv : '0;
				if (step_go) begin
					rsp_d.exploration_now = rate_next;
					rsp_d.steps_done      = step_q + 23'd1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= 3'd0;
			dcnt_q   <= 3'd0;
			rdv_q    <= 1'b0;
			rate_q   <= EXPLORE_RATE_RST;
			step_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= emit;
			case (state_q)
				ST_IDLE: begin
					rd_cnt_q <= 3'd0;
					dcnt_q   <= 3'd0;
					rdv_q    <= 1'b0;
					if (!empty) begin
						if (head.kind == K_SELECT || head.kind == K_UPDATE) begin
							state_q <= ST_RD;
						end else if (head.kind == K_UPD_MISS) begin
							state_q <= ST_MULG;
						end
					end
				end
				ST_RD: begin
					rdv_q <= rd_cnt_q < n_reads;
					if (rd_cnt_q < n_reads) begin
						rd_cnt_q <= rd_cnt_q + 3'd1;
					end
					if (rdv_q) begin
						dcnt_q <= dcnt_q + 3'd1;
						if (dcnt_q == n_reads - 3'd1) begin
							state_q <= is_upd ? ST_MULG : ST_SEL;
						end
					end
				end
				ST_SEL:  state_q <= ST_IDLE;
				ST_MULG: state_q <= ST_TGT;
				ST_TGT:  state_q <= ST_MULA;
				ST_MULA: state_q <= ST_MULB;
				ST_MULB: state_q <= ST_WB;
				ST_WB: begin
					state_q <= ST_IDLE;
					if (step_go) begin
						rate_q <= rate_next;
						step_q <= step_q + 23'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (pop) begin
			cmd_q <= head;
		end
		// Absorb row entries with a running first-maximum, then the old entry.
		if (state_q == ST_RD && rdv_q) begin
			if (dcnt_q[2]) begin
				old_q <= rd_val;
			end else if (dcnt_q == 3'd0 || rd_val > best_q) begin
				best_q <= rd_val;
				col_q  <= dcnt_q[1:0];
			end
		end
		if (state_q == ST_MULG) begin
			gprod_q <= $signed({1'b0, cfg.discount}) * best_q;
			dprod_q <= rate_q * cfg.explore_decay;
		end
		if (state_q == ST_TGT) begin
			tgt_q <= 26'(cmd_q.item.reward) + 26'(gprod_q >>> 16);
		end
		if (state_q == ST_MULA) begin
			pa_q <= $signed({1'b0, lr_inv}) * old_q;
		end
		if (state_q == ST_MULB) begin
			pb_q <= $signed({1'b0, cfg.alpha}) * tgt_q;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: design/tabular_q_learning_engine_top.sv
// Top level of the tabular Q-learning engine: configuration registers, front, queue and back.
//
// Items enter on req when start is high and busy is low. Each item gives exactly one
// result on rsp, marked by done for a single cycle; the receiver has no way to hold
// results off, so it must take every result in the cycle that done is high.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data, which is
// always ready; writes are meant to happen only while no item is in flight.
// The front classifies each item and drops it into a two-entry queue, so start can be
// taken while the back part is still working. The back part works on one item at a
// time, and its pace is set by the single port of the table memory, which serves every
// row read one entry per cycle, followed by the update multiplies. An action select
// makes four reads (the row of the state) and an update makes five (the row of the next
// state, then the old entry), followed by the states MULG, TGT, MULA and MULB and the
// write back. An update whose rows are out of range skips the reads; a write or an item
// with no table access gives its result straight from idle.
// Reset clears the queue, sets the exploration rate to nearly one, the step count to
// zero and the registers to their defaults. Table entries are undefined until written;
// there is no clearing pass, so no idle time follows reset.
module tabular_q_learning_engine_top import tqle_pkg::*; #(
	parameter int NUM_STATES = NUM_STATES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tqle_req_t         req,
	output logic              done,
	output tqle_rsp_t         rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [STEP_W-1:0] cfg_data
);

	tqle_cfg_t cfg_q;
	tqle_cmd_t push_cmd;
	tqle_cmd_t head_cmd;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha                <= ALPHA_RST;
			cfg_q.discount             <= DISCOUNT_RST;
			cfg_q.explore_decay        <= EXPLORE_DECAY_RST;
			cfg_q.explore_floor        <= EXPLORE_FLOOR_RST;
			cfg_q.training_steps_limit <= STEPS_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ALPHA:         cfg_q.alpha                <= cfg_data[RATE_W-1:0];
				REG_DISCOUNT:      cfg_q.discount             <= cfg_data[RATE_W-1:0];
				REG_EXPLORE_DECAY: cfg_q.explore_decay        <= cfg_data[RATE_W-1:0];
				REG_EXPLORE_FLOOR: cfg_q.explore_floor        <= cfg_data[RATE_W-1:0];
				REG_STEPS_LIMIT:   cfg_q.training_steps_limit <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	tqle_front #(
		.NUM_STATES(NUM_STATES)
	) u_front (
		.start(start),
		.req  (req),
		.full (full),
		.busy (busy),
		.push (push),
		.cmd  (push_cmd)
	);

	tqle_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_cmd),
		.pop   (pop),
		.rdata (head_cmd),
		.full  (full),
		.empty (empty)
	);

	tqle_back #(
		.NUM_STATES(NUM_STATES)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.empty (empty),
		.head  (head_cmd),
		.pop   (pop),
		.done  (done),
		.rsp   (rsp)
	);

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("queue reports full and empty at once");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("item pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("back part popped an empty queue");

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !empty)
		else $error("accepted item did not reach the queue");

endmodule
